[hdl/servo_pi_dual_pwm_controller_unit_defines.svh]
// Assertion macros for the servo PI and dual PWM controller.
// Used by the top level only; the macros expect clk and rst_n in scope.
`ifndef SERVO_PI_DUAL_PWM_CONTROLLER_UNIT_DEFINES_SVH
`define SERVO_PI_DUAL_PWM_CONTROLLER_UNIT_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define SPDC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define SPDC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies another in the next cycle.
`define SPDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/spdc_pkg.sv]
// Package of the servo PI and dual PWM controller: codes, constants and types.
// No dependencies; used by the input channel interface and the top level.
package spdc_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_PERIOD = 2'd1,
    CMD_MATCH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MOTOR1_SPEED   = 2'd0,
    REG_MOTOR1_REVERSE = 2'd1,
    REG_SERVO_TARGET   = 2'd2
  } reg_idx_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int SAMPLE_W   = 10;

  localparam logic [7:0] SPEED_MIN   = 8'd6;
  localparam logic [7:0] SPEED_MAX   = 8'd250;
  localparam logic [7:0] PWM_CUTOFF  = 8'd7;
  localparam logic [7:0] REF_OFFSET  = 8'd60;
  localparam logic [5:0] TARGET_MAX  = 6'd40;
  localparam logic [5:0] TARGET_RST  = 6'd20;
  localparam logic [7:0] ERR_CAP     = 8'd15;
  localparam int         P_SHIFT     = 4;
  localparam int         I_SHIFT     = 2;
  localparam logic [7:0] PHASE_RST   = 8'd3;

  typedef struct packed {
    logic       pwm1_level;
    logic       pwm2_level;
    logic       motor2_reverse;
    logic [7:0] timer_compare;
    logic       sample_request;
    logic       report_valid;
    logic [7:0] measured;
    logic [7:0] drive;
  } result_t;

endpackage

[hdl/spdc_if.sv]
// Valid/ready channel interfaces of the servo PI and dual PWM controller.
// Depends on spdc_pkg for the command code and sample width.
interface spdc_in_if
  import spdc_pkg::*;
();
  logic                valid;
  logic                ready;
  cmd_t                cmd;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, cmd, sample, input ready);
  modport sink   (input valid, cmd, sample, output ready);
endinterface

interface spdc_out_if;
  logic       valid;
  logic       ready;
  logic       pwm1_level;
  logic       pwm2_level;
  logic       motor2_reverse;
  logic [7:0] timer_compare;
  logic       sample_request;
  logic       report_valid;
  logic [7:0] measured;
  logic [7:0] drive;

  modport source (output valid, pwm1_level, pwm2_level, motor2_reverse, timer_compare,
                  sample_request, report_valid, measured, drive, input ready);
  modport sink   (input valid, pwm1_level, pwm2_level, motor2_reverse, timer_compare,
                  sample_request, report_valid, measured, drive, output ready);
endinterface

[hdl/servo_pi_dual_pwm_controller_unit.sv]
// Servo PI controller with a two-channel PWM event sequencer.
//
// Input channel in_chan carries one event per word: an ADC sample, a PWM
// period start or a timer compare match. Output channel out_chan returns
// exactly one result word per event: PWM levels, motor two direction, the
// next timer compare, a sample request, and the measured position and drive.
// The configuration port cfg_* writes motor one speed and direction and the
// servo target; the user is to write it only while no event is in flight, and the block does not enforce this.
//
// An event is held in the input register; its result is then computed from
// the controller state and lands in the output register once that register
// is empty or being read. One event is taken every cycle while the receiver
// does not stall; the state update is done in the compute stage.
// When the receiver stalls, the output register holds its word, the input
// register holds the next event and in_chan.ready drops once both are full.
// Synchronous reset clears both stages and loads the controller state: drive
// and motor two compare 6, integral 0, phase count 3, both PWM levels low.
`include "servo_pi_dual_pwm_controller_unit_defines.svh"

module servo_pi_dual_pwm_controller_unit
  import spdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  spdc_in_if.sink               in_chan,
  spdc_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [7:0] m1_speed_r;
  logic       m1_reverse_r;
  logic [5:0] target_r;

  // Controller state.
  logic [7:0] integral_r, integral_nxt;
  logic [7:0] drive_r, drive_nxt;
  logic       reverse_two_r, reverse_two_nxt;
  logic [7:0] compare_two_r, compare_two_nxt;
  logic [7:0] phase_r, phase_nxt;
  logic [7:0] later_r, later_nxt;
  logic [1:0] levels_r, levels_nxt;
  logic [7:0] measured_r, measured_nxt;

  // Input and output stages.
  logic                s1_v_r;
  cmd_t                s1_cmd_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                out_v_r;
  result_t             out_r, result_nxt;

  logic advance;
  logic take_in;

  assign advance        = s1_v_r && (!out_v_r || out_chan.ready);
  assign take_in        = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = !s1_v_r || advance;

  // Sample path and PI law.
  logic [7:0] meas, ref_pos, err, int_room, int_sum, p_err, p_term, i_term, speed;
  logic       rev_new;
  logic       int_clear;

  always_comb begin
    meas    = s1_sample_r[SAMPLE_W-1:2];
    ref_pos = {2'b00, target_r} + REF_OFFSET;
    if (meas > ref_pos) begin
      err     = meas - ref_pos;
      rev_new = 1'b1;
    end else begin
      err     = ref_pos - meas;
      rev_new = 1'b0;
    end
    // The error never exceeds 195, so the headroom does not wrap.
    int_room = SPEED_MAX - err;
    int_sum  = (int_room > integral_r) ? integral_r + err : SPEED_MAX;
    p_err    = (err < ERR_CAP) ? err : ERR_CAP;
    p_term   = p_err << P_SHIFT;
    i_term   = int_sum >> I_SHIFT;
    if (err != 8'd0) begin
      speed = (i_term < SPEED_MAX - p_term) ? p_term + i_term : SPEED_MAX;
    end else begin
      speed = 8'd0;
    end
    int_clear = 1'b0;
    if (speed < SPEED_MIN) begin
      speed     = SPEED_MIN;
      int_clear = 1'b1;
    end
  end

  // Motor one compare from the clamped requested speed.
  logic [7:0] m1_clamped, c1;

  always_comb begin
    m1_clamped = m1_speed_r;
    if (m1_clamped > SPEED_MAX) m1_clamped = SPEED_MAX;
    if (m1_clamped < SPEED_MIN) m1_clamped = SPEED_MIN;
    c1 = m1_reverse_r ? 8'd0 - m1_clamped : m1_clamped;
  end

  // Event decode and state update.
  always_comb begin
    integral_nxt    = integral_r;
    drive_nxt       = drive_r;
    reverse_two_nxt = reverse_two_r;
    compare_two_nxt = compare_two_r;
    phase_nxt       = phase_r;
    later_nxt       = later_r;
    levels_nxt      = levels_r;
    measured_nxt    = measured_r;
    result_nxt      = '0;

    case (s1_cmd_r)
      CMD_SAMPLE: begin
        measured_nxt    = meas;
        reverse_two_nxt = rev_new;
        integral_nxt    = int_clear ? 8'd0 : int_sum;
        drive_nxt       = speed;
        compare_two_nxt = rev_new ? 8'd0 - speed : speed;
        result_nxt.report_valid = 1'b1;
      end
      CMD_PERIOD: begin
        if (c1 < compare_two_r) begin
          result_nxt.timer_compare = c1;
          later_nxt = compare_two_r;
          phase_nxt = 8'd1;
        end else if (compare_two_r < c1) begin
          result_nxt.timer_compare = compare_two_r;
          later_nxt = c1;
          phase_nxt = 8'd2;
        end else begin
          result_nxt.timer_compare = c1;
          later_nxt = c1;
          phase_nxt = 8'd3;
        end
        levels_nxt = {compare_two_r >= PWM_CUTOFF, c1 >= PWM_CUTOFF};
        result_nxt.sample_request = 1'b1;
      end
      CMD_MATCH: begin
        if (phase_r[0]) levels_nxt[0] = 1'b0;
        if (phase_r[1]) levels_nxt[1] = 1'b0;
        result_nxt.timer_compare = later_r;
        phase_nxt = phase_r + 8'd1;
      end
      default: begin
      end
    endcase

    result_nxt.pwm1_level     = levels_nxt[0];
    result_nxt.pwm2_level     = levels_nxt[1];
    result_nxt.motor2_reverse = reverse_two_nxt;
    result_nxt.measured       = measured_nxt;
    result_nxt.drive          = drive_nxt;
  end

  // Control state, configuration and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      m1_speed_r    <= SPEED_MIN;
      m1_reverse_r  <= 1'b0;
      target_r      <= TARGET_RST;
      integral_r    <= 8'd0;
      drive_r       <= SPEED_MIN;
      reverse_two_r <= 1'b0;
      compare_two_r <= SPEED_MIN;
      phase_r       <= PHASE_RST;
      later_r       <= 8'd0;
      levels_r      <= 2'b00;
      measured_r    <= 8'd0;
    end else begin
      if (take_in) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end

      if (advance) begin
        integral_r    <= integral_nxt;
        drive_r       <= drive_nxt;
        reverse_two_r <= reverse_two_nxt;
        compare_two_r <= compare_two_nxt;
        phase_r       <= phase_nxt;
        later_r       <= later_nxt;
        levels_r      <= levels_nxt;
        measured_r    <= measured_nxt;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_MOTOR1_SPEED:   m1_speed_r   <= cfg_wdata;
          REG_MOTOR1_REVERSE: m1_reverse_r <= cfg_wdata[0];
          REG_SERVO_TARGET: begin
            target_r   <= (cfg_wdata[5:0] > TARGET_MAX) ? TARGET_MAX : cfg_wdata[5:0];
            integral_r <= 8'd0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_cmd_r    <= in_chan.cmd;
      s1_sample_r <= in_chan.sample;
    end
    if (advance) begin
      out_r <= result_nxt;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.pwm1_level     = out_r.pwm1_level;
  assign out_chan.pwm2_level     = out_r.pwm2_level;
  assign out_chan.motor2_reverse = out_r.motor2_reverse;
  assign out_chan.timer_compare  = out_r.timer_compare;
  assign out_chan.sample_request = out_r.sample_request;
  assign out_chan.report_valid   = out_r.report_valid;
  assign out_chan.measured       = out_r.measured;
  assign out_chan.drive          = out_r.drive;

  `SPDC_ASSERT_ALWAYS(a_drive_range, drive_r >= SPEED_MIN && drive_r <= SPEED_MAX,
                      "drive out of range")
  `SPDC_ASSERT_ALWAYS(a_integral_cap, integral_r <= SPEED_MAX, "integral above its cap")
  `SPDC_ASSERT_NEXT(a_stage_hold, s1_v_r && !advance,
                    s1_v_r && $stable(s1_cmd_r) && $stable(s1_sample_r), "stalled event lost")
  `SPDC_ASSERT_IMPLY(a_floor_clears,
                     out_v_r && out_r.report_valid && out_r.drive == SPEED_MIN,
                     integral_r == 8'd0, "drive floor without integral clear")

endmodule
